// ===== sv/qaar_pkg.sv =====
package qaar_pkg;

  localparam int COMP_WIDTH      = 16;
  localparam int TRIG_ITERATIONS = 16;
  localparam int FRAC_BITS       = COMP_WIDTH - 2;
  localparam int RQ              = 28;
  localparam int MB_W            = ((COMP_WIDTH > 16) ? COMP_WIDTH : 16) + 1;
  localparam int PW              = 32 + MB_W;
  localparam int ACC_W           = PW + 3;
  localparam int CW              = 34;
  localparam int OUT_SHR         = (COMP_WIDTH >= 16) ? COMP_WIDTH - 16 : 0;
  localparam int OUT_SHL         = (COMP_WIDTH < 16) ? 16 - COMP_WIDTH : 0;

  localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [31:0]           op_a_t;
  typedef logic signed [MB_W-1:0]       op_b_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [CW-1:0]         cordic_t;

  typedef struct packed {
    logic               op;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [15:0]        angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] quat_w_out;
    logic signed [15:0] quat_x_out;
    logic signed [15:0] quat_y_out;
    logic signed [15:0] quat_z_out;
    logic               zero_axis;
  } out_item_t;

  localparam logic OP_ROTATE   = 1'b0;
  localparam logic OP_IDENTITY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_NUM_MUL,
    ST_NUM_ACC,
    ST_DIV,
    ST_DIV_WAIT,
    ST_HAM_MUL,
    ST_HAM_ACC,
    ST_HAM_SAVE,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic mul_en;
    logic neg;
    logic acc_en;
    logic first;
  } mac_ctl_t;

  // Operand selects: a is 0 for the rotation scalar, 1..3 for the rotation
  // vector; b is 0 for the stored scalar, 1..3 for the stored vector.
  typedef struct packed {
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic       neg;
  } ham_term_t;

  function automatic logic [30:0] atan_entry(input logic [4:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:  v = 31'd536870912;
      5'd1:  v = 31'd316933406;
      5'd2:  v = 31'd167458907;
      5'd3:  v = 31'd85004756;
      5'd4:  v = 31'd42667331;
      5'd5:  v = 31'd21354465;
      5'd6:  v = 31'd10679838;
      5'd7:  v = 31'd5340245;
      5'd8:  v = 31'd2670163;
      5'd9:  v = 31'd1335087;
      5'd10: v = 31'd667544;
      5'd11: v = 31'd333772;
      5'd12: v = 31'd166886;
      5'd13: v = 31'd83443;
      5'd14: v = 31'd41722;
      5'd15: v = 31'd20861;
      5'd16: v = 31'd10430;
      5'd17: v = 31'd5215;
      5'd18: v = 31'd2608;
      5'd19: v = 31'd1304;
      5'd20: v = 31'd652;
      5'd21: v = 31'd326;
      5'd22: v = 31'd163;
      5'd23: v = 31'd81;
      5'd24: v = 31'd41;
      5'd25: v = 31'd20;
      5'd26: v = 31'd10;
      5'd27: v = 31'd5;
      5'd28: v = 31'd3;
      5'd29: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  function automatic ham_term_t ham_sel(input logic [3:0] t);
    ham_term_t h;
    unique case (t)
      4'd0:  h = '{a_sel: 2'd0, b_sel: 2'd0, neg: 1'b0};
      4'd1:  h = '{a_sel: 2'd1, b_sel: 2'd1, neg: 1'b1};
      4'd2:  h = '{a_sel: 2'd2, b_sel: 2'd2, neg: 1'b1};
      4'd3:  h = '{a_sel: 2'd3, b_sel: 2'd3, neg: 1'b1};
      4'd4:  h = '{a_sel: 2'd1, b_sel: 2'd0, neg: 1'b0};
      4'd5:  h = '{a_sel: 2'd0, b_sel: 2'd1, neg: 1'b0};
      4'd6:  h = '{a_sel: 2'd3, b_sel: 2'd2, neg: 1'b0};
      4'd7:  h = '{a_sel: 2'd2, b_sel: 2'd3, neg: 1'b1};
      4'd8:  h = '{a_sel: 2'd2, b_sel: 2'd0, neg: 1'b0};
      4'd9:  h = '{a_sel: 2'd0, b_sel: 2'd2, neg: 1'b0};
      4'd10: h = '{a_sel: 2'd1, b_sel: 2'd3, neg: 1'b0};
      4'd11: h = '{a_sel: 2'd3, b_sel: 2'd1, neg: 1'b1};
      4'd12: h = '{a_sel: 2'd3, b_sel: 2'd0, neg: 1'b0};
      4'd13: h = '{a_sel: 2'd0, b_sel: 2'd3, neg: 1'b0};
      4'd14: h = '{a_sel: 2'd2, b_sel: 2'd1, neg: 1'b0};
      4'd15: h = '{a_sel: 2'd1, b_sel: 2'd2, neg: 1'b1};
      default: h = '{a_sel: 2'd0, b_sel: 2'd0, neg: 1'b0};
    endcase
    return h;
  endfunction

  // Round half up from the product scale and saturate to the state range.
  function automatic comp_t round_sat(input acc_t acc);
    acc_t v;
    acc_t hi;
    acc_t lo;
    v  = (acc + (acc_t'(1) <<< (RQ - 1))) >>> RQ;
    hi = (acc_t'(1) <<< (COMP_WIDTH - 1)) - acc_t'(1);
    lo = -(acc_t'(1) <<< (COMP_WIDTH - 1));
    if (v > hi) begin
      return comp_t'(hi);
    end else if (v < lo) begin
      return comp_t'(lo);
    end
    return comp_t'(v);
  endfunction

  function automatic logic signed [15:0] to_out(input comp_t v);
    logic signed [63:0] e;
    e = 64'(v);
    if (COMP_WIDTH >= 16) begin
      return 16'(e >>> OUT_SHR);
    end
    return 16'(e <<< OUT_SHL);
  endfunction

endpackage

// ===== sv/qaar_cordic.sv =====
module qaar_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [15:0]         angle,
  output logic                busy,
  output qaar_pkg::cordic_t   cos_q30,
  output qaar_pkg::cordic_t   sin_q30
);
  import qaar_pkg::*;

  cordic_t    x_r, y_r, z_r;
  cordic_t    z0;
  cordic_t    xs, ys, at;
  logic [4:0] it_r;
  logic       flip_r;
  logic       busy_r;

  assign z0 = CW'({angle, 15'd0});
  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;
  assign at = CW'({1'b0, atan_entry(it_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (it_r == 5'(TRIG_ITERATIONS - 1))) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r  <= CORDIC_GAIN;
      y_r  <= '0;
      it_r <= '0;
      if (z0 > QUARTER_TURN) begin
        z_r    <= HALF_TURN - z0;
        flip_r <= 1'b1;
      end else begin
        z_r    <= z0;
        flip_r <= 1'b0;
      end
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
      it_r <= it_r + 5'd1;
    end
  end

  assign busy    = busy_r;
  assign cos_q30 = flip_r ? -x_r : x_r;
  assign sin_q30 = y_r;

endmodule

// ===== sv/qaar_isqrt.sv =====
module qaar_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] mag2,
  output logic        busy,
  output logic [31:0] root
);
  import qaar_pkg::*;

  logic [63:0] n_r, res_r, bit_r;
  logic [63:0] trial;
  logic        busy_r;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
    end
  end

  // Digit-by-digit root of mag2 scaled by 2^32, one result bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= {mag2, 32'd0};
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_r   <= n_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = res_r[31:0];

endmodule

// ===== sv/qaar_div.sv =====
module qaar_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] numer,
  input  logic [31:0] den,
  output logic        busy,
  output logic [31:0] quo
);
  import qaar_pkg::*;

  logic [31:0] rem_r, nlo_r, quo_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [32:0] t;
  logic        ge;

  assign t  = {rem_r, nlo_r[31]};
  assign ge = t >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt_r == 5'd31)) begin
      busy_r <= 1'b0;
    end
  end

  // Restoring division; the quotient is known to fit in 32 bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= numer[63:32];
      nlo_r <= numer[31:0];
      quo_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 32'(t - {1'b0, den}) : t[31:0];
      nlo_r <= nlo_r << 1;
      quo_r <= {quo_r[30:0], ge};
      cnt_r <= cnt_r + 5'd1;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// ===== sv/qaar_mac.sv =====
module qaar_mac (
  input  logic               clk,
  input  qaar_pkg::mac_ctl_t ctl,
  input  qaar_pkg::op_a_t    op_a,
  input  qaar_pkg::op_b_t    op_b,
  output qaar_pkg::acc_t     acc
);
  import qaar_pkg::*;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_r;
  logic                 neg_r;
  acc_t                 acc_r;
  acc_t                 term;

  assign prod = op_a * op_b;
  assign term = neg_r ? -acc_t'(prod_r) : acc_t'(prod_r);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod;
      neg_r  <= ctl.neg;
    end
    if (ctl.acc_en) begin
      acc_r <= (ctl.first ? acc_t'(0) : acc_r) + term;
    end
  end

  assign acc = acc_r;

endmodule

// ===== sv/quaternion_axis_angle_rotate.sv =====
// Orientation quaternion rotator. The block holds an orientation quaternion
// in signed Q1.14, identity after reset, and composes it with the rotation
// given by each rotate transaction (an axis of any scale and a binary angle
// where 65536 is one turn) as the Hamilton product q times r. An identity
// transaction restores the identity quaternion. A rotate transaction with
// an all-zero axis leaves the state alone and sets zero_axis. Every input
// transaction produces exactly one output transaction carrying the state
// after the step. Items are processed one at a time: in_stall is high from
// acceptance until the result has been loaded into the output register. An
// identity or zero-axis item bypasses the square root, the CORDIC, the
// divider and the Hamilton product; a rotation runs the bit-serial divider
// once for each of the three axis components and the square root, which
// overlaps the CORDIC. One shared multiplier with a registered product and
// accumulator forms the squared axis length, the dividends and the sixteen
// terms of the Hamilton product.
module quaternion_axis_angle_rotate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qaar_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qaar_pkg::out_item_t out_data
);
  import qaar_pkg::*;

  seq_state_t state_r, state_nxt;

  in_item_t   item_r;
  logic [3:0] term_r;
  comp_t      q_w_r;
  comp_t      q_v_r [3];
  comp_t      nq_r  [3];
  op_a_t      u_r   [3];
  op_a_t      rw_r;
  op_a_t      s_r;
  logic [31:0] len_r;
  logic       flag_r;
  logic       num_neg_r;
  out_item_t  out_r;
  logic       out_valid_r;

  mac_ctl_t   mac_ctl;
  op_a_t      op_a;
  op_b_t      op_b;
  acc_t       acc;
  logic       sqrt_go, cordic_go, div_go;
  logic       sqrt_busy, cordic_busy, div_busy;
  logic [31:0] root;
  logic [31:0] quo;
  cordic_t    cos_q30, sin_q30;
  logic [63:0] div_numer;
  logic       in_take;
  logic       out_load;
  logic signed [15:0] axis_k;
  ham_term_t  hs;
  logic signed [32:0] q_signed;
  comp_t      rs;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Axis component for the current index of the per-component loops.
  always_comb begin
    unique case (term_r[1:0])
      2'd0:    axis_k = item_r.axis_x;
      2'd1:    axis_k = item_r.axis_y;
      default: axis_k = item_r.axis_z;
    endcase
  end

  assign hs        = ham_sel(term_r);
  // The divider works on magnitudes; the sign of the dividend is taken from
  // the accumulator directly because num_neg_r only settles at the start edge.
  assign div_numer = 64'(acc[ACC_W-1] ? -acc : acc) << 16;
  assign q_signed  = num_neg_r ? -{1'b0, quo} : {1'b0, quo};
  assign rs        = round_sat(acc);

  qaar_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  qaar_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_go),
    .mag2  (acc[31:0]),
    .busy  (sqrt_busy),
    .root  (root)
  );

  qaar_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_go),
    .angle   (item_r.angle),
    .busy    (cordic_busy),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  qaar_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .numer (div_numer),
    .den   (len_r),
    .busy  (div_busy),
    .quo   (quo)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.op == OP_IDENTITY) ? ST_DONE : ST_SQ_MUL;
        end
      end
      ST_SQ_MUL:  state_nxt = ST_SQ_ACC;
      ST_SQ_ACC:  state_nxt = (term_r == 4'd2) ? ST_ROOT : ST_SQ_MUL;
      ST_ROOT:    state_nxt = (acc == acc_t'(0)) ? ST_DONE : ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (!sqrt_busy && !cordic_busy) begin
          state_nxt = ST_NUM_MUL;
        end
      end
      ST_NUM_MUL: state_nxt = ST_NUM_ACC;
      ST_NUM_ACC: state_nxt = ST_DIV;
      ST_DIV:     state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          state_nxt = (term_r == 4'd2) ? ST_HAM_MUL : ST_NUM_MUL;
        end
      end
      ST_HAM_MUL: state_nxt = ST_HAM_ACC;
      ST_HAM_ACC: state_nxt = (term_r[1:0] == 2'd3) ? ST_HAM_SAVE : ST_HAM_MUL;
      ST_HAM_SAVE: state_nxt = (term_r == 4'd15) ? ST_DONE : ST_HAM_MUL;
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer: multiplier operands, unit starts.
  always_comb begin
    mac_ctl   = '0;
    op_a      = '0;
    op_b      = '0;
    sqrt_go   = 1'b0;
    cordic_go = 1'b0;
    div_go    = 1'b0;
    unique case (state_r)
      ST_SQ_MUL: begin
        op_a           = op_a_t'(axis_k);
        op_b           = op_b_t'(axis_k);
        mac_ctl.mul_en = 1'b1;
      end
      ST_SQ_ACC: begin
        mac_ctl.acc_en = 1'b1;
        mac_ctl.first  = (term_r == 4'd0);
      end
      ST_ROOT: begin
        sqrt_go   = (acc != acc_t'(0));
        cordic_go = (acc != acc_t'(0));
      end
      ST_NUM_MUL: begin
        op_a           = s_r;
        op_b           = op_b_t'(axis_k);
        mac_ctl.mul_en = 1'b1;
      end
      ST_NUM_ACC: begin
        mac_ctl.acc_en = 1'b1;
        mac_ctl.first  = 1'b1;
      end
      ST_DIV: div_go = 1'b1;
      ST_HAM_MUL: begin
        op_a           = (hs.a_sel == 2'd0) ? rw_r : u_r[2'(hs.a_sel - 2'd1)];
        op_b           = (hs.b_sel == 2'd0) ? op_b_t'(q_w_r)
                                            : op_b_t'(q_v_r[2'(hs.b_sel - 2'd1)]);
        mac_ctl.mul_en = 1'b1;
        mac_ctl.neg    = hs.neg;
      end
      ST_HAM_ACC: begin
        mac_ctl.acc_en = 1'b1;
        mac_ctl.first  = (term_r[1:0] == 2'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      q_w_r       <= comp_t'(1) <<< FRAC_BITS;
      q_v_r[0]    <= '0;
      q_v_r[1]    <= '0;
      q_v_r[2]    <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_take && (in_data.op == OP_IDENTITY)) begin
        q_w_r    <= comp_t'(1) <<< FRAC_BITS;
        q_v_r[0] <= '0;
        q_v_r[1] <= '0;
        q_v_r[2] <= '0;
      end
      // The new state is committed only after all sixteen terms have used
      // the old one.
      if ((state_r == ST_HAM_SAVE) && (term_r == 4'd15)) begin
        q_w_r    <= nq_r[0];
        q_v_r[0] <= nq_r[1];
        q_v_r[1] <= nq_r[2];
        q_v_r[2] <= rs;
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          item_r <= in_data;
          term_r <= '0;
          flag_r <= 1'b0;
        end
      end
      ST_SQ_ACC: term_r <= (term_r == 4'd2) ? 4'd0 : term_r + 4'd1;
      ST_ROOT: begin
        if (acc == acc_t'(0)) begin
          flag_r <= 1'b1;
        end
      end
      ST_ROOT_WAIT: begin
        len_r <= root;
        s_r   <= op_a_t'(sin_q30);
        rw_r  <= op_a_t'((cos_q30 + cordic_t'(2)) >>> 2);
      end
      ST_DIV: num_neg_r <= acc[ACC_W-1];
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          u_r[term_r[1:0]] <= op_a_t'((q_signed + 33'sd2) >>> 2);
          term_r           <= (term_r == 4'd2) ? 4'd0 : term_r + 4'd1;
        end
      end
      ST_HAM_ACC: begin
        if (term_r[1:0] != 2'd3) begin
          term_r <= term_r + 4'd1;
        end
      end
      ST_HAM_SAVE: begin
        if (term_r[3:2] != 2'd3) begin
          nq_r[term_r[3:2]] <= rs;
        end
        term_r <= term_r + 4'd1;
      end
      ST_DONE: begin
        if (out_load) begin
          out_r.quat_w_out <= to_out(q_w_r);
          out_r.quat_x_out <= to_out(q_v_r[0]);
          out_r.quat_y_out <= to_out(q_v_r[1]);
          out_r.quat_z_out <= to_out(q_v_r[2]);
          out_r.zero_axis  <= flag_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== test/qaar_checker.sv =====
module qaar_checker
  import qaar_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ATAN_Q32 [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  longint    orient_w;
  longint    orient_v [3];
  out_item_t expected_q [$];

  function automatic longint fit_state(input longint acc);
    longint lim;
    longint r;
    lim = longint'(1) <<< (COMP_WIDTH - 1);
    r = (acc + (longint'(1) <<< (RQ - 1))) >>> RQ;
    if (r > lim - 1) r = lim - 1;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic signed [15:0] state_to_q14(input longint v);
    if (COMP_WIDTH >= 16) return 16'(v >>> (COMP_WIDTH - 16));
    return 16'(v <<< (16 - COMP_WIDTH));
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  // Apply one transaction to the model orientation and return the result.
  function automatic out_item_t rotate_orientation(input in_item_t t);
    out_item_t r;
    longint a [3];
    longint u [3];
    longint z, x, y, nx, len, rw, w, v0, v1, v2;
    longint unsigned mag2;
    logic mirrored;
    r.zero_axis = 1'b0;
    if (t.op == OP_IDENTITY) begin
      orient_w = longint'(1) <<< FRAC_BITS;
      orient_v = '{0, 0, 0};
    end else begin
      a[0] = t.axis_x;
      a[1] = t.axis_y;
      a[2] = t.axis_z;
      mag2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      if (mag2 == 0) begin
        r.zero_axis = 1'b1;
      end else begin
        len = int_sqrt(mag2 << 32);
        z = longint'(t.angle) <<< 15;
        x = 652032874;
        y = 0;
        mirrored = 1'b0;
        if (z > 64'sd1073741824) begin
          z = 64'sd2147483648 - z;
          mirrored = 1'b1;
        end
        for (int i = 0; i < TRIG_ITERATIONS && i < 30; i++) begin
          if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - ATAN_Q32[i];
          end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + ATAN_Q32[i];
          end
          x = nx;
        end
        if (mirrored) x = -x;
        // SystemVerilog division truncates toward zero, as required.
        for (int k = 0; k < 3; k++) u[k] = ((y * a[k] * 65536) / len + 2) >>> 2;
        rw = (x + 2) >>> 2;
        w = orient_w;
        v0 = orient_v[0];
        v1 = orient_v[1];
        v2 = orient_v[2];
        orient_w = fit_state(w * rw - v0 * u[0] - v1 * u[1] - v2 * u[2]);
        orient_v[0] = fit_state(w * u[0] + rw * v0 + v1 * u[2] - v2 * u[1]);
        orient_v[1] = fit_state(w * u[1] + rw * v1 + v2 * u[0] - v0 * u[2]);
        orient_v[2] = fit_state(w * u[2] + rw * v2 + v0 * u[1] - v1 * u[0]);
      end
    end
    r.quat_w_out = state_to_q14(orient_w);
    r.quat_x_out = state_to_q14(orient_v[0]);
    r.quat_y_out = state_to_q14(orient_v[1]);
    r.quat_z_out = state_to_q14(orient_v[2]);
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      orient_w = longint'(1) <<< FRAC_BITS;
      orient_v = '{0, 0, 0};
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(rotate_orientation(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected output transaction %h", out_data);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.quat_w_out !== e.quat_w_out) begin
            $error("quat_w_out expected %0d got %0d", e.quat_w_out, out_data.quat_w_out);
            fail_count++;
          end
          if (out_data.quat_x_out !== e.quat_x_out) begin
            $error("quat_x_out expected %0d got %0d", e.quat_x_out, out_data.quat_x_out);
            fail_count++;
          end
          if (out_data.quat_y_out !== e.quat_y_out) begin
            $error("quat_y_out expected %0d got %0d", e.quat_y_out, out_data.quat_y_out);
            fail_count++;
          end
          if (out_data.quat_z_out !== e.quat_z_out) begin
            $error("quat_z_out expected %0d got %0d", e.quat_z_out, out_data.quat_z_out);
            fail_count++;
          end
          if (out_data.zero_axis !== e.zero_axis) begin
            $error("zero_axis expected %0d got %0d", e.zero_axis, out_data.zero_axis);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== test/tb_quaternion_axis_angle_rotate.sv =====
// Stimulus and verdict for the quaternion rotator. The checker beside the
// block predicts every output transaction and counts mismatches; this module
// only feeds input transactions, applies backpressure and decides the outcome.
module tb_quaternion_axis_angle_rotate;
  import qaar_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 400;
  // The limit allows for every item being a rotation plus long stalls on both
  // sides, several times over.
  localparam longint CYCLE_LIMIT = 1000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        send_idle_pct = 37;
  int        recv_idle_pct = 51;
  longint    cycle_count = 0;

  always #4 clk = ~clk;

  quaternion_axis_angle_rotate i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  qaar_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The receiver stalls at random, one decision per falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // The watchdog ends a hung run with the failing verdict.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("quaternion_axis_angle_rotate regression: fail");
      $finish;
    end
  end

  // Present one transaction at a falling edge and hold it until accepted.
  // Valid stays high into the next transaction when no idle gap is drawn.
  task automatic send_item(input in_item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_item_t make_rotate(input int x, input int y, input int z,
                                           input int ang);
    in_item_t t;
    t.op = OP_ROTATE;
    t.axis_x = 16'(x);
    t.axis_y = 16'(y);
    t.axis_z = 16'(z);
    t.angle = 16'(ang);
    return t;
  endfunction

  // Random transactions are mostly full-range rotations, with some tiny or
  // single-axis vectors, zero axes and identity resets mixed in.
  function automatic in_item_t random_item();
    in_item_t t;
    int pick;
    t = in_item_t'({$urandom, $urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 6) begin
      t.op = OP_IDENTITY;
    end else begin
      t.op = OP_ROTATE;
      if (pick < 12) begin
        t.axis_x = '0;
        t.axis_y = '0;
        t.axis_z = '0;
      end else if (pick < 25) begin
        t.axis_x = 16'($signed($urandom_range(6)) - 3);
        t.axis_y = 16'($signed($urandom_range(6)) - 3);
        t.axis_z = 16'($signed($urandom_range(6)) - 3);
      end else if (pick < 35) begin
        t.axis_y = '0;
        t.axis_z = '0;
      end
    end
    return t;
  endfunction

  initial begin
    in_item_t t;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, both operations, zero axis, quarter-turn
    // mirroring, full-scale axes and an identity transaction with junk fields.
    send_item(make_rotate(0, 0, 0, 16'h4000));
    send_item(make_rotate(1, 0, 0, 16'h4000));
    send_item(make_rotate(0, 1, 0, 16'h8000));
    send_item(make_rotate(0, 0, 32767, 16'hFFFF));
    send_item(make_rotate(-32768, -32768, -32768, 0));
    send_item(make_rotate(32767, 32767, 32767, 16'h7FFF));
    send_item(make_rotate(-1, 0, 0, 16'h8001));
    send_item(make_rotate(3, -4, 12, 16'hC000));
    t = make_rotate(-1, -1, -1, 16'hFFFF);
    t.op = OP_IDENTITY;
    send_item(t);
    send_item(make_rotate(0, 0, 0, 16'hFFFF));
    send_item(make_rotate(-32768, 0, 0, 16'h2000));
    send_item(make_rotate(0, -32768, 1, 16'hA000));
    send_item(make_rotate(21845, -10923, 5461, 16'h5555));
    send_item(make_rotate(7, 7, 7, 16'h0001));

    // Hold off until the block has drained every expected result.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    send_item(make_rotate(100, 200, 300, 16'h1234));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 37;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_item(random_item());
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("quaternion_axis_angle_rotate regression: pass");
    end else begin
      $display("quaternion_axis_angle_rotate regression: fail");
    end
    $finish;
  end
endmodule
